### rtl/core/cas_pkg.sv
package cas_pkg;

    // Vector geometry.
    localparam int MAX_DIM = 1024;
    localparam int ADDR_W  = $clog2(MAX_DIM);
    localparam int CNT_W   = $clog2(MAX_DIM + 2);

    // Element, accumulator and score widths.
    localparam int ELEM_W  = 16;
    localparam int ID_W    = 64;
    localparam int SCORE_W = 17;
    localparam int NORM_W  = $clog2(MAX_DIM) + 31;
    localparam int DOT_W   = NORM_W + 1;
    localparam int PROD_W  = 2 * NORM_W;

    // Score search operands: |2s - 65537| and its square.
    localparam int AM_W    = 17;
    localparam int MUL_W   = 2 * DOT_W + 32;
    localparam int MB_W    = (DOT_W > 2 * AM_W) ? DOT_W : 2 * AM_W;

    // Operation codes.
    localparam logic [1:0] OP_QUERY = 2'd0;
    localparam logic [1:0] OP_CAND  = 2'd1;
    localparam logic [1:0] OP_EMPTY = 2'd2;

    // Score constants in Q1.16.
    localparam logic [SCORE_W-1:0] SCORE_ZERO = 17'd0;
    localparam logic [SCORE_W-1:0] SCORE_HALF = 17'd32768;
    localparam logic [SCORE_W-1:0] SCORE_ONE  = 17'd65536;

    // One finished candidate handed from the front to the back.
    typedef struct packed {
        logic [ID_W-1:0]          doc_id;
        logic                     usable;
        logic [NORM_W-1:0]        qnorm;
        logic [NORM_W-1:0]        cnorm;
        logic signed [DOT_W-1:0]  dot;
    } job_t;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_CHECK,
        BK_NORM_PROD,
        BK_DOT_SQ,
        BK_SEARCH,
        BK_AM_SQ,
        BK_LHS,
        BK_DONE
    } back_state_t;

endpackage

### rtl/core/cas_in_if.sv
interface cas_in_if;
    import cas_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [1:0]                operation;
    logic signed [ELEM_W-1:0]  element_value;
    logic                      last;
    logic [ID_W-1:0]           doc_id;

    modport source (output valid, operation, element_value, last, doc_id, input ready);
    modport sink   (input valid, operation, element_value, last, doc_id, output ready);
endinterface

### rtl/core/cas_out_if.sv
interface cas_out_if;
    import cas_pkg::*;

    logic                valid;
    logic                ready;
    logic [ID_W-1:0]     doc_id_res;
    logic [SCORE_W-1:0]  score;
    logic                usable;

    modport source (output valid, doc_id_res, score, usable, input ready);
    modport sink   (input valid, doc_id_res, score, usable, output ready);
endinterface

### rtl/core/cas_ram.sv
module cas_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/core/cas_front.sv
module cas_front (
    input  logic          clk,
    input  logic          rst_n,
    cas_in_if.sink        req,
    output cas_pkg::job_t job_data,
    output logic          job_valid,
    input  logic          job_full
);
    import cas_pkg::*;

    // Work handed from the decode stage to the accumulate stage.
    typedef struct packed {
        logic                      sclr;
        logic                      acc_norm;
        logic                      acc_dot;
        logic                      emit;
        logic                      usable;
        logic signed [ELEM_W-1:0]  value;
        logic [ID_W-1:0]           doc_id;
        logic [NORM_W-1:0]         qnorm;
    } acc_op_t;

    logic [CNT_W-1:0]  qlen_reg, qlen_next;
    logic [CNT_W-1:0]  qwi_reg, qwi_next;
    logic [NORM_W-1:0] qnorm_reg, qnorm_next;
    logic [CNT_W-1:0]  cc_reg, cc_next;
    logic              loading_reg, loading_next;

    logic              bv_reg;
    acc_op_t           op_reg, op_next;
    logic [NORM_W-1:0] cnorm_reg, cnorm_next;
    logic signed [DOT_W-1:0] dot_reg, dot_next;

    logic              accept;
    logic              b_adv;
    logic [CNT_W-1:0]  qwi_cur;
    logic [NORM_W-1:0] qn_cur;
    logic [CNT_W-1:0]  qlen_eff;
    logic [CNT_W-1:0]  cc_new;
    logic signed [31:0] sq_a_s;
    logic signed [31:0] sq_b_s;
    logic signed [31:0] prod_s;
    logic signed [ELEM_W-1:0] q_elem;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [ELEM_W-1:0] ram_rdata;

    // The accumulate stage stalls only when a result meets a full queue.
    assign b_adv     = !(op_reg.emit && job_full);
    assign req.ready = !bv_reg || b_adv;
    assign accept    = req.valid && req.ready;

    cas_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (MAX_DIM)
    ) u_query_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (req.element_value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Decode: query bookkeeping, candidate count and the query read.
    always_comb
    begin
        qwi_cur  = loading_reg ? qwi_reg : '0;
        qn_cur   = loading_reg ? qnorm_reg : '0;
        qlen_eff = loading_reg ? '0 : qlen_reg;
        sq_a_s   = req.element_value * req.element_value;
        cc_new   = cc_reg;

        qlen_next    = qlen_reg;
        qwi_next     = qwi_reg;
        qnorm_next   = qnorm_reg;
        cc_next      = cc_reg;
        loading_next = loading_reg;
        ram_we       = 1'b0;
        ram_waddr    = qwi_cur[ADDR_W-1:0];
        ram_re       = 1'b0;
        ram_raddr    = cc_reg[ADDR_W-1:0];

        op_next          = '0;
        op_next.value    = req.element_value;
        op_next.doc_id   = req.doc_id;
        op_next.qnorm    = qnorm_reg;

        if (accept)
        begin
            case (req.operation)
                OP_QUERY:
                begin
                    loading_next = 1'b1;
                    if (!loading_reg)
                    begin
                        qlen_next    = '0;
                        cc_next      = '0;
                        op_next.sclr = 1'b1;
                    end
                    if (qwi_cur < CNT_W'(MAX_DIM))
                    begin
                        ram_we     = 1'b1;
                        qnorm_next = qn_cur + NORM_W'(unsigned'(sq_a_s));
                        qwi_next   = qwi_cur + 1'b1;
                    end
                    else
                    begin
                        qnorm_next = qn_cur;
                        qwi_next   = CNT_W'(MAX_DIM + 1);
                    end
                    if (req.last)
                    begin
                        qlen_next    = qwi_next;
                        loading_next = 1'b0;
                    end
                end
                OP_CAND:
                begin
                    if (loading_reg)
                    begin
                        loading_next = 1'b0;
                        qlen_next    = '0;
                    end
                    if (cc_reg < CNT_W'(MAX_DIM))
                    begin
                        op_next.acc_norm = 1'b1;
                        op_next.acc_dot  = cc_reg < qlen_eff;
                        ram_re           = 1'b1;
                        cc_new           = cc_reg + 1'b1;
                    end
                    else
                    begin
                        cc_new = CNT_W'(MAX_DIM + 1);
                    end
                    cc_next = cc_new;
                    if (req.last)
                    begin
                        op_next.emit   = 1'b1;
                        op_next.usable = (qlen_eff != '0) && (qlen_eff <= CNT_W'(MAX_DIM))
                                         && (cc_new == qlen_eff);
                        cc_next        = '0;
                    end
                end
                OP_EMPTY:
                begin
                    if (loading_reg)
                    begin
                        loading_next = 1'b0;
                        qlen_next    = '0;
                    end
                    cc_next      = '0;
                    op_next.emit = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Accumulate: candidate norm and dot product against the stored query.
    always_comb
    begin
        q_elem = signed'(ram_rdata);
        sq_b_s = op_reg.value * op_reg.value;
        prod_s = op_reg.value * q_elem;

        job_data.doc_id = op_reg.doc_id;
        job_data.usable = op_reg.usable;
        job_data.qnorm  = op_reg.qnorm;
        job_data.cnorm  = cnorm_reg + (op_reg.acc_norm ? NORM_W'(unsigned'(sq_b_s)) : '0);
        job_data.dot    = dot_reg + (op_reg.acc_dot ? DOT_W'(prod_s) : '0);
        job_valid       = bv_reg && op_reg.emit;

        cnorm_next = cnorm_reg;
        dot_next   = dot_reg;
        if (bv_reg && b_adv)
        begin
            if (op_reg.sclr || op_reg.emit)
            begin
                cnorm_next = '0;
                dot_next   = '0;
            end
            else
            begin
                cnorm_next = job_data.cnorm;
                dot_next   = job_data.dot;
            end
        end
    end

    // Control and accumulator registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qlen_reg    <= '0;
            qwi_reg     <= '0;
            qnorm_reg   <= '0;
            cc_reg      <= '0;
            loading_reg <= 1'b0;
            bv_reg      <= 1'b0;
            cnorm_reg   <= '0;
            dot_reg     <= '0;
        end
        else
        begin
            qlen_reg    <= qlen_next;
            qwi_reg     <= qwi_next;
            qnorm_reg   <= qnorm_next;
            cc_reg      <= cc_next;
            loading_reg <= loading_next;
            cnorm_reg   <= cnorm_next;
            dot_reg     <= dot_next;
            if (accept)
            begin
                bv_reg <= 1'b1;
            end
            else if (b_adv)
            begin
                bv_reg <= 1'b0;
            end
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= op_next;
        end
    end

    // A stored query never grows beyond the store plus the overflow mark.
    assert property (@(posedge clk) disable iff (!rst_n)
        qwi_reg <= CNT_W'(MAX_DIM + 1))
        else $error("query index out of range");

    // A stalled accumulate stage blocks the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        (bv_reg && op_reg.emit && job_full) |-> !req.ready)
        else $error("input taken while accumulate stage stalled");

    // A completed query clears the loading flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.operation == OP_QUERY && req.last) |=> !loading_reg)
        else $error("query load not closed");

endmodule

### rtl/core/cas_queue.sv
module cas_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cas_pkg::job_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output cas_pkg::job_t pop_data
);
    import cas_pkg::*;

    job_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign full      = count_reg == 2'd2;
    assign not_empty = count_reg != 2'd0;
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = slot_reg[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    // Item storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // The count moves by at most one per cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> count_reg == $past(count_reg) + 2'd1)
        else $error("queue count lost a push");

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2)
        else $error("queue overfilled");

    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree when empty");

endmodule

### rtl/core/cas_back.sv
module cas_back (
    input  logic          clk,
    input  logic          rst_n,
    input  cas_pkg::job_t job,
    input  logic          job_valid,
    output logic          job_pop,
    cas_out_if.source     res
);
    import cas_pkg::*;

    back_state_t         state_reg, state_next;
    job_t                job_reg, job_next;
    logic [PROD_W-1:0]   p_reg, p_next;
    logic [MUL_W-1:0]    d_reg, d_next;
    logic [SCORE_W-1:0]  lo_reg, lo_next;
    logic [SCORE_W-1:0]  hi_reg, hi_next;
    logic [SCORE_W-1:0]  mid_reg, mid_next;
    logic [SCORE_W-1:0]  score_reg, score_next;
    logic [MUL_W-1:0]    ma_reg, ma_next;
    logic [MB_W-1:0]     mb_reg, mb_next;
    logic [MUL_W-1:0]    macc_reg, macc_next;

    logic                res_valid_reg, res_valid_next;
    logic [ID_W-1:0]     res_id_reg, res_id_next;
    logic [SCORE_W-1:0]  res_score_reg, res_score_next;
    logic                res_usable_reg, res_usable_next;

    logic                mul_done;
    logic [MUL_W-1:0]    macc_step;
    logic [17:0]         mid_w;
    logic [SCORE_W-1:0]  mid;
    logic [17:0]         two_mid;
    logic                m_pos;
    logic [17:0]         am_w;
    logic [AM_W-1:0]     am;
    logic                dot_neg;
    logic [DOT_W-1:0]    dot_abs;
    logic                shortcut;
    logic                fits;
    logic                out_free;

    // Shared helpers: serial multiplier step and search midpoint.
    always_comb
    begin
        mul_done  = mb_reg == '0;
        macc_step = macc_reg + (mb_reg[0] ? ma_reg : '0);
        mid_w     = {1'b0, lo_reg} + (({1'b0, hi_reg} - {1'b0, lo_reg} + 18'd1) >> 1);
        mid       = mid_w[SCORE_W-1:0];
        two_mid   = {mid, 1'b0};
        m_pos     = mid >= 17'd32769;
        am_w      = m_pos ? (two_mid - 18'd65537) : (18'd65537 - two_mid);
        am        = am_w[AM_W-1:0];
        dot_neg   = job_reg.dot[DOT_W-1];
        dot_abs   = dot_neg ? unsigned'(-job_reg.dot) : unsigned'(job_reg.dot);
        shortcut  = (!m_pos && !dot_neg) || (m_pos && dot_neg);
        fits      = m_pos ? (macc_reg <= d_reg) : (macc_reg >= d_reg);
        out_free  = !res_valid_reg || res.ready;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = BK_CHECK;
                end
            end
            BK_CHECK:
            begin
                if (!job_reg.usable || job_reg.qnorm == '0 || job_reg.cnorm == '0)
                begin
                    state_next = BK_DONE;
                end
                else
                begin
                    state_next = BK_NORM_PROD;
                end
            end
            BK_NORM_PROD:
            begin
                if (mul_done)
                begin
                    state_next = BK_DOT_SQ;
                end
            end
            BK_DOT_SQ:
            begin
                if (mul_done)
                begin
                    state_next = BK_SEARCH;
                end
            end
            BK_SEARCH:
            begin
                if (lo_reg == hi_reg)
                begin
                    state_next = BK_DONE;
                end
                else if (!shortcut)
                begin
                    state_next = BK_AM_SQ;
                end
            end
            BK_AM_SQ:
            begin
                if (mul_done)
                begin
                    state_next = BK_LHS;
                end
            end
            BK_LHS:
            begin
                if (mul_done)
                begin
                    state_next = BK_SEARCH;
                end
            end
            BK_DONE:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Datapath and outputs for each state.
    always_comb
    begin
        job_next        = job_reg;
        p_next          = p_reg;
        d_next          = d_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        score_next      = score_reg;
        ma_next         = ma_reg << 1;
        mb_next         = mb_reg >> 1;
        macc_next       = macc_step;
        job_pop         = 1'b0;
        res_valid_next  = res_valid_reg && !res.ready;
        res_id_next     = res_id_reg;
        res_score_next  = res_score_reg;
        res_usable_next = res_usable_reg;

        case (state_reg)
            BK_IDLE:
            begin
                job_pop  = job_valid;
                job_next = job;
            end
            BK_CHECK:
            begin
                score_next = job_reg.usable ? SCORE_HALF : SCORE_ZERO;
                ma_next    = MUL_W'(job_reg.qnorm);
                mb_next    = MB_W'(job_reg.cnorm);
                macc_next  = '0;
            end
            BK_NORM_PROD:
            begin
                if (mul_done)
                begin
                    p_next    = macc_reg[PROD_W-1:0];
                    ma_next   = MUL_W'(dot_abs);
                    mb_next   = MB_W'(dot_abs);
                    macc_next = '0;
                end
            end
            BK_DOT_SQ:
            begin
                if (mul_done)
                begin
                    d_next  = {macc_reg[MUL_W-33:0], 32'd0};
                    lo_next = SCORE_ZERO;
                    hi_next = SCORE_ONE;
                end
            end
            BK_SEARCH:
            begin
                if (lo_reg == hi_reg)
                begin
                    score_next = lo_reg;
                end
                else if (!m_pos && !dot_neg)
                begin
                    lo_next = mid;
                end
                else if (m_pos && dot_neg)
                begin
                    hi_next = mid - 1'b1;
                end
                else
                begin
                    mid_next  = mid;
                    ma_next   = MUL_W'(am);
                    mb_next   = MB_W'(am);
                    macc_next = '0;
                end
            end
            BK_AM_SQ:
            begin
                if (mul_done)
                begin
                    ma_next   = MUL_W'(p_reg);
                    mb_next   = MB_W'(macc_reg);
                    macc_next = '0;
                end
            end
            BK_LHS:
            begin
                if (mul_done)
                begin
                    // Keep the half of the range that still satisfies the bound.
                    if (fits)
                    begin
                        lo_next = mid_reg;
                    end
                    else
                    begin
                        hi_next = mid_reg - 1'b1;
                    end
                end
            end
            BK_DONE:
            begin
                if (out_free)
                begin
                    res_valid_next  = 1'b1;
                    res_id_next     = job_reg.doc_id;
                    res_score_next  = score_reg;
                    res_usable_next = job_reg.usable;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign res.valid      = res_valid_reg;
    assign res.doc_id_res = res_id_reg;
    assign res.score      = res_score_reg;
    assign res.usable     = res_usable_reg;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        job_reg        <= job_next;
        p_reg          <= p_next;
        d_reg          <= d_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        score_reg      <= score_next;
        ma_reg         <= ma_next;
        mb_reg         <= mb_next;
        macc_reg       <= macc_next;
        res_id_reg     <= res_id_next;
        res_score_reg  <= res_score_next;
        res_usable_reg <= res_usable_next;
    end

    // The search range never inverts.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_SEARCH) |-> (lo_reg <= hi_reg))
        else $error("search range inverted");

    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.score <= SCORE_ONE))
        else $error("score above one");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.usable) |-> (res.score == SCORE_ZERO))
        else $error("unusable candidate with nonzero score");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_LHS && mul_done) |=> (state_reg == BK_SEARCH))
        else $error("bound check did not return to search");

endmodule

### rtl/core/cosine_anchor_score.sv
// Cosine anchor score: a query vector of Q1.15 elements is loaded first (operation 0) and
// kept in a 1024-entry store; each candidate then streams in one element per cycle
// (operation 1) and its dot product and squared norm are accumulated, and on its last element
// one result carries the doc id and score = round((cos + 1) / 2) in Q1.16, or score 0 with
// usable low for an empty, mismatched or overlong candidate or when no query is loaded.
// The front end takes one item per cycle while the queue has room. Scoring runs in a back
// end behind a two-item queue, built around a shift-add multiplier: a scored candidate
// needs the norm product and squared dot, then a binary search of up to 17 steps, each
// of which may square and multiply on the multiplier; an unusable or zero-norm candidate
// skips these. When the queue is full the input waits for the back end.
module cosine_anchor_score (
    input  logic clk,
    input  logic rst_n,
    cas_in_if.sink    req,
    cas_out_if.source res
);
    import cas_pkg::*;

    job_t job_in;
    job_t job_out;
    logic job_push;
    logic job_full;
    logic job_pop;
    logic job_ready;

    cas_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .job_data  (job_in),
        .job_valid (job_push),
        .job_full  (job_full)
    );

    cas_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job_in),
        .full      (job_full),
        .pop       (job_pop),
        .not_empty (job_ready),
        .pop_data  (job_out)
    );

    cas_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job_out),
        .job_valid (job_ready),
        .job_pop   (job_pop),
        .res       (res)
    );

endmodule
